// ===== src/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg
// types and constants shared by the projectile feeder sequencer
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int unsigned InBytes  = 12;
	localparam int unsigned OutBytes = 3;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_ARM_LEVEL     = 3'd0,
		REG_FIRE_LEVEL    = 3'd1,
		REG_HEAT_RESERVE  = 3'd2,
		REG_MIN_WHEEL_RPM = 3'd3,
		REG_JAM_CURRENT   = 3'd4,
		REG_JAM_TICKS     = 3'd5,
		REG_REVERSE_TICKS = 3'd6
	} reg_idx_t;

	// register reset values
	localparam logic signed [10:0] ArmLevelRst     = 11'sd120;
	localparam logic signed [10:0] FireLevelRst    = 11'sd600;
	localparam logic [15:0]        HeatReserveRst  = 16'd100;
	localparam logic [14:0]        MinWheelRpmRst  = 15'd3900;
	localparam logic [14:0]        JamCurrentRst   = 15'd7500;
	localparam logic [9:0]         JamTicksRst     = 10'd500;
	localparam logic [7:0]         ReverseTicksRst = 8'd70;

	// targets
	localparam logic [12:0]       WheelSlow = 13'd4000;
	localparam logic [12:0]       WheelFast = 13'd6000;
	localparam logic [7:0]        SlowCode  = 8'd10;
	localparam logic signed [4:0] FeedFwd   = -5'sd7;
	localparam logic signed [4:0] FeedRev   = 5'sd5;
	localparam logic signed [4:0] FeedHold  = 5'sd0;
	localparam logic signed [4:0] PushSlow  = -5'sd7;
	localparam logic signed [4:0] PushFast  = -5'sd10;

	// timing
	localparam logic [7:0] PushWindow = 8'd55;
	localparam logic [7:0] RefireGap  = 8'd60;
	localparam logic [7:0] TimerMax   = 8'd150;
	localparam logic [9:0] BlockMax   = 10'd1023;
	localparam logic [7:0] ReverseMax = 8'd255;

	typedef struct packed {
		logic [5:0]          pad;
		logic signed [15:0]  feeder_current;
		logic signed [15:0]  right_rpm;
		logic signed [15:0]  left_rpm;
		logic signed [16:0]  heat_margin;
		logic [7:0]          speed_limit;
		logic                shooter_power;
		logic                ball_switch_open;
		logic signed [10:0]  wheel;
		logic                mouse_left;
		logic                ctrl_key;
		logic                toggle_key;
		logic                switch_up;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]         pad;
		logic               jammed;
		logic               clear_loops;
		logic signed [4:0]  feeder_speed_target;
		logic [12:0]        wheel_speed_target;
	} out_beat_t;

endpackage

// ===== src/projectile_feeder_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// projectile_feeder_sequencer_top
// per-tick flywheel and feeder targets with arming, firing and jam reverse
// an accepted input beat's result is registered and is on m_tdata in the cycle after it
// throughput: one beat per cycle; the only stall is a full output register
// the whole tick update is combinational logic into the state and result regs
// reset: state and output valid cleared, shot timer at 150, registers at defaults
// ----------------------------------------------------------------------------
module projectile_feeder_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// switch_up, toggle_key, ctrl_key, mouse_left, wheel, ball_switch_open,
	// shooter_power, speed_limit, heat_margin, left_rpm, right_rpm,
	// feeder_current, zero fill
	input  logic [pfs_pkg::InBytes*8-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// wheel_speed_target, feeder_speed_target, clear_loops, jammed, zero fill
	output logic [pfs_pkg::OutBytes*8-1:0] m_tdata,
	input  logic                          wr_en,
	input  logic [pfs_pkg::CfgIdxW-1:0]   wr_index,
	input  logic [pfs_pkg::CfgDataW-1:0]  wr_data
);

	pfs_pkg::in_beat_t  in_b;
	pfs_pkg::out_beat_t out_d, out_q;

	logic signed [10:0] arm_level_q, fire_level_q;
	logic [15:0]        heat_reserve_q;
	logic [14:0]        min_wheel_rpm_q, jam_current_q;
	logic [9:0]         jam_ticks_q;
	logic [7:0]         reverse_ticks_q;

	logic       enable_toggle_q, toggle_prev_q, mouse_prev_q, mouse_prev2_q;
	logic       armed_q, fire_pending_q, jam_flag_q;
	logic [7:0] shot_timer_q, reverse_count_q;
	logic [9:0] block_count_q;

	logic       enable_toggle_d, armed_d, fire_pending_d, jam_flag_d, enabled;
	logic [7:0] shot_timer_d, reverse_count_d;
	logic [9:0] block_count_d;

	logic       accept, out_valid_q;

	assign in_b     = pfs_pkg::in_beat_t'(s_tdata);
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		logic [9:0]         bc_inc;
		logic [7:0]         rc_inc;
		logic [7:0]         timer;
		logic signed [4:0]  feed;
		logic [12:0]        wheel_t;
		logic signed [16:0] neg_jam;
		logic signed [17:0] heat_res_s;
		logic [16:0]        la, ra;
		logic               slow;

		enable_toggle_d = enable_toggle_q ^ (!toggle_prev_q && in_b.toggle_key);
		enabled         = (in_b.switch_up || enable_toggle_d) && in_b.shooter_power;
		slow            = (in_b.speed_limit == pfs_pkg::SlowCode);
		block_count_d   = block_count_q;
		reverse_count_d = reverse_count_q;
		jam_flag_d      = jam_flag_q;
		armed_d         = armed_q;
		fire_pending_d  = fire_pending_q;
		feed            = pfs_pkg::FeedHold;
		wheel_t         = '0;
		neg_jam         = -$signed({2'b00, jam_current_q});
		heat_res_s      = $signed({2'b00, heat_reserve_q});
		bc_inc          = (block_count_q == pfs_pkg::BlockMax) ? block_count_q
		                  : block_count_q + 10'd1;
		rc_inc          = (reverse_count_q == pfs_pkg::ReverseMax) ? reverse_count_q
		                  : reverse_count_q + 8'd1;

		if (enabled) begin
			if ($signed({in_b.feeder_current[15], in_b.feeder_current}) < neg_jam) begin
				block_count_d = bc_inc;
				if (bc_inc > jam_ticks_q) begin
					jam_flag_d    = 1'b1;
					block_count_d = '0;
				end
			end else begin
				block_count_d = '0;
			end
			if (jam_flag_d) begin
				reverse_count_d = rc_inc;
				if (rc_inc > reverse_ticks_q) begin
					reverse_count_d = '0;
					jam_flag_d      = 1'b0;
				end
			end
			wheel_t = slow ? pfs_pkg::WheelSlow : pfs_pkg::WheelFast;
			if (!jam_flag_d) begin
				feed = in_b.ball_switch_open ? pfs_pkg::FeedFwd : pfs_pkg::FeedHold;
				if (in_b.wheel < arm_level_q)
					armed_d = 1'b1;
				if (armed_d && (in_b.wheel > fire_level_q || (!mouse_prev2_q && mouse_prev_q))
				    && !in_b.ball_switch_open
				    && $signed({in_b.heat_margin[16], in_b.heat_margin}) >= heat_res_s) begin
					fire_pending_d = 1'b1;
					armed_d        = 1'b0;
				end
			end else begin
				feed = pfs_pkg::FeedRev;
			end
		end

		timer = shot_timer_q;
		if (fire_pending_d && timer > pfs_pkg::RefireGap) begin
			timer          = '0;
			fire_pending_d = 1'b0;
		end
		if (timer < pfs_pkg::PushWindow)
			feed = slow ? pfs_pkg::PushSlow : pfs_pkg::PushFast;
		if (in_b.ctrl_key)
			feed = pfs_pkg::PushFast;
		la = in_b.left_rpm[15] ? 17'(-$signed({in_b.left_rpm[15], in_b.left_rpm}))
		     : {1'b0, in_b.left_rpm};
		ra = in_b.right_rpm[15] ? 17'(-$signed({in_b.right_rpm[15], in_b.right_rpm}))
		     : {1'b0, in_b.right_rpm};
		if (la < {2'b00, min_wheel_rpm_q} || ra < {2'b00, min_wheel_rpm_q})
			feed = pfs_pkg::FeedHold;
		shot_timer_d = (timer < pfs_pkg::TimerMax) ? timer + 8'd1 : timer;

		out_d                     = '0;
		out_d.wheel_speed_target  = wheel_t;
		out_d.feeder_speed_target = feed;
		out_d.clear_loops         = !enabled;
		out_d.jammed              = jam_flag_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_level_q     <= pfs_pkg::ArmLevelRst;
			fire_level_q    <= pfs_pkg::FireLevelRst;
			heat_reserve_q  <= pfs_pkg::HeatReserveRst;
			min_wheel_rpm_q <= pfs_pkg::MinWheelRpmRst;
			jam_current_q   <= pfs_pkg::JamCurrentRst;
			jam_ticks_q     <= pfs_pkg::JamTicksRst;
			reverse_ticks_q <= pfs_pkg::ReverseTicksRst;
		end else if (wr_en) begin
			case (pfs_pkg::reg_idx_t'(wr_index))
				pfs_pkg::REG_ARM_LEVEL:     arm_level_q     <= $signed(wr_data[10:0]);
				pfs_pkg::REG_FIRE_LEVEL:    fire_level_q    <= $signed(wr_data[10:0]);
				pfs_pkg::REG_HEAT_RESERVE:  heat_reserve_q  <= wr_data;
				pfs_pkg::REG_MIN_WHEEL_RPM: min_wheel_rpm_q <= wr_data[14:0];
				pfs_pkg::REG_JAM_CURRENT:   jam_current_q   <= wr_data[14:0];
				pfs_pkg::REG_JAM_TICKS:     jam_ticks_q     <= wr_data[9:0];
				pfs_pkg::REG_REVERSE_TICKS: reverse_ticks_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_toggle_q <= 1'b0;
			toggle_prev_q   <= 1'b0;
			mouse_prev_q    <= 1'b0;
			mouse_prev2_q   <= 1'b0;
			armed_q         <= 1'b0;
			fire_pending_q  <= 1'b0;
			jam_flag_q      <= 1'b0;
			shot_timer_q    <= pfs_pkg::TimerMax;
			block_count_q   <= '0;
			reverse_count_q <= '0;
		end else if (accept) begin
			enable_toggle_q <= enable_toggle_d;
			toggle_prev_q   <= in_b.toggle_key;
			mouse_prev_q    <= in_b.mouse_left;
			mouse_prev2_q   <= mouse_prev_q;
			armed_q         <= armed_d;
			fire_pending_q  <= fire_pending_d;
			jam_flag_q      <= jam_flag_d;
			shot_timer_q    <= shot_timer_d;
			block_count_q   <= block_count_d;
			reverse_count_q <= reverse_count_d;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= out_d;
		end
	end

endmodule

// ===== verif/projectile_feeder_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projectile_feeder_sequencer_top_tb
// Drives control ticks into the feeder sequencer and checks every result beat
// against an in-bench prediction of the launcher targets. It runs a short
// directed sequence, random ticks under default, jam-prone, extreme and random
// register settings with random idling on both stream sides, then back to back.
// ----------------------------------------------------------------------------
module projectile_feeder_sequencer_top_tb;

	localparam int unsigned StuckLimit = 1000;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [pfs_pkg::InBytes*8-1:0]   s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [pfs_pkg::OutBytes*8-1:0]  m_tdata;
	logic                            wr_en     = 1'b0;
	logic [pfs_pkg::CfgIdxW-1:0]     wr_index  = pfs_pkg::REG_ARM_LEVEL;
	logic [pfs_pkg::CfgDataW-1:0]    wr_data   = '0;

	projectile_feeder_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register copies
	logic signed [10:0] c_arm      = pfs_pkg::ArmLevelRst;
	logic signed [10:0] c_fire     = pfs_pkg::FireLevelRst;
	logic [15:0]        c_heat     = pfs_pkg::HeatReserveRst;
	logic [14:0]        c_minrpm   = pfs_pkg::MinWheelRpmRst;
	logic [14:0]        c_jamcur   = pfs_pkg::JamCurrentRst;
	logic [9:0]         c_jamticks = pfs_pkg::JamTicksRst;
	logic [7:0]         c_revticks = pfs_pkg::ReverseTicksRst;

	// launcher state
	logic       en_latch  = 1'b0;
	logic       tkey_q    = 1'b0;
	logic       mouse_q   = 1'b0;
	logic       mouse_qq  = 1'b0;
	logic       armed_q   = 1'b0;
	logic       fire_pend = 1'b0;
	logic       jam_q     = 1'b0;
	logic [7:0] shot_tmr  = pfs_pkg::TimerMax;
	logic [9:0] blk_cnt   = '0;
	logic [7:0] rev_cnt   = '0;

	pfs_pkg::out_beat_t target_q[$];
	pfs_pkg::out_beat_t got_beat;
	pfs_pkg::out_beat_t want_beat;
	bit          idling   = 1'b1;
	bit          jam_push = 1'b0;
	int unsigned err_cnt  = 0;
	int unsigned n_ticks  = 0;
	int unsigned n_res    = 0;
	int unsigned n_shots  = 0;
	int unsigned n_jams   = 0;
	int unsigned n_cfg    = 0;
	int unsigned stall_left = 0;
	int unsigned stuck    = 0;

	function automatic pfs_pkg::out_beat_t tick_targets(pfs_pkg::in_beat_t b);
		pfs_pkg::out_beat_t r;
		logic              on;
		logic signed [4:0] feed;
		logic [12:0]       wtgt;
		int                whl, heat, fcur, lmag, rmag;
		r    = '0;
		feed = pfs_pkg::FeedHold;
		wtgt = '0;
		whl  = $signed(b.wheel);
		heat = $signed(b.heat_margin);
		fcur = $signed(b.feeder_current);
		lmag = $signed(b.left_rpm);
		rmag = $signed(b.right_rpm);
		if (!tkey_q && b.toggle_key)
			en_latch = !en_latch;
		tkey_q = b.toggle_key;
		on = (b.switch_up || en_latch) && b.shooter_power;
		if (on) begin
			if (fcur < -int'(c_jamcur)) begin
				if (blk_cnt < pfs_pkg::BlockMax)
					blk_cnt++;
				if (blk_cnt > c_jamticks) begin
					jam_q   = 1'b1;
					blk_cnt = '0;
					n_jams++;
				end
			end else begin
				blk_cnt = '0;
			end
			if (jam_q) begin
				if (rev_cnt < pfs_pkg::ReverseMax)
					rev_cnt++;
				if (rev_cnt > c_revticks) begin
					rev_cnt = '0;
					jam_q   = 1'b0;
				end
			end
			wtgt = (b.speed_limit == pfs_pkg::SlowCode) ? pfs_pkg::WheelSlow
			       : pfs_pkg::WheelFast;
			if (!jam_q) begin
				feed = b.ball_switch_open ? pfs_pkg::FeedFwd : pfs_pkg::FeedHold;
				if (whl < int'(c_arm))
					armed_q = 1'b1;
				if (armed_q && (whl > int'(c_fire) || (!mouse_qq && mouse_q)) &&
				    !b.ball_switch_open && heat >= int'(c_heat)) begin
					fire_pend = 1'b1;
					armed_q   = 1'b0;
				end
			end else begin
				feed = pfs_pkg::FeedRev;
			end
		end
		if (fire_pend && shot_tmr > pfs_pkg::RefireGap) begin
			shot_tmr  = '0;
			fire_pend = 1'b0;
			n_shots++;
		end
		if (shot_tmr < pfs_pkg::PushWindow)
			feed = (b.speed_limit == pfs_pkg::SlowCode) ? pfs_pkg::PushSlow
			       : pfs_pkg::PushFast;
		if (b.ctrl_key)
			feed = pfs_pkg::PushFast;
		if (lmag < 0)
			lmag = -lmag;
		if (rmag < 0)
			rmag = -rmag;
		if (lmag < int'(c_minrpm) || rmag < int'(c_minrpm))
			feed = pfs_pkg::FeedHold;
		if (shot_tmr < pfs_pkg::TimerMax)
			shot_tmr++;
		mouse_qq = mouse_q;
		mouse_q  = b.mouse_left;
		r.wheel_speed_target  = wtgt;
		r.feeder_speed_target = feed;
		r.clear_loops         = !on;
		r.jammed              = jam_q;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		err_cnt++;
		$display("mismatch on result %0d: %s got %0d want %0d", n_res, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = m_tdata;
			if (target_q.size() == 0) begin
				report_mismatch("beat with nothing pending, wheel target",
					got_beat.wheel_speed_target, 0);
			end else begin
				want_beat = target_q.pop_front();
				if (got_beat.wheel_speed_target != want_beat.wheel_speed_target)
					report_mismatch("wheel_speed_target", got_beat.wheel_speed_target,
						want_beat.wheel_speed_target);
				if (got_beat.feeder_speed_target != want_beat.feeder_speed_target)
					report_mismatch("feeder_speed_target",
						$signed(got_beat.feeder_speed_target),
						$signed(want_beat.feeder_speed_target));
				if (got_beat.clear_loops != want_beat.clear_loops)
					report_mismatch("clear_loops", got_beat.clear_loops,
						want_beat.clear_loops);
				if (got_beat.jammed != want_beat.jammed)
					report_mismatch("jammed", got_beat.jammed, want_beat.jammed);
				if (got_beat.pad != '0)
					report_mismatch("zero fill", got_beat.pad, 0);
			end
			n_res++;
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		if (idling && stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left = $urandom_range(0, 18);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
			stuck = 0;
		else
			stuck++;
		if (stuck >= StuckLimit) begin
			$display("watchdog: no beat moved for %0d cycles", StuckLimit);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_tick(pfs_pkg::in_beat_t b);
		if (idling && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		target_q.push_back(tick_targets(b));
		n_ticks++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (target_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(pfs_pkg::reg_idx_t idx, logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
	endtask

	task automatic apply_config(int arm, int fire, int heat, int minrpm, int jamcur,
	                            int jticks, int rticks);
		settle();
		write_reg(pfs_pkg::REG_ARM_LEVEL, 16'(arm));
		write_reg(pfs_pkg::REG_FIRE_LEVEL, 16'(fire));
		write_reg(pfs_pkg::REG_HEAT_RESERVE, 16'(heat));
		write_reg(pfs_pkg::REG_MIN_WHEEL_RPM, 16'(minrpm));
		write_reg(pfs_pkg::REG_JAM_CURRENT, 16'(jamcur));
		write_reg(pfs_pkg::REG_JAM_TICKS, 16'(jticks));
		write_reg(pfs_pkg::REG_REVERSE_TICKS, 16'(rticks));
		wr_en      <= 1'b0;
		c_arm      = 11'(arm);
		c_fire     = 11'(fire);
		c_heat     = 16'(heat);
		c_minrpm   = 15'(minrpm);
		c_jamcur   = 15'(jamcur);
		c_jamticks = 10'(jticks);
		c_revticks = 8'(rticks);
		n_cfg++;
	endtask

	function automatic logic [15:0] rand_rpm();
		int m;
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: m = int'(c_minrpm) - int'($urandom_range(0, 1));
			default: m = int'($urandom_range(int'(c_minrpm), 32767));
		endcase
		return $urandom_range(0, 1) ? 16'(m) : 16'(-m);
	endfunction

	function automatic pfs_pkg::in_beat_t random_tick();
		pfs_pkg::in_beat_t b;
		int       h;
		int       mag;
		b = '0;
		b.switch_up  = ($urandom_range(0, 3) != 0);
		b.toggle_key = ($urandom_range(0, 3) == 0);
		b.ctrl_key   = ($urandom_range(0, 15) == 0);
		b.mouse_left = ($urandom_range(0, 2) == 0);
		case ($urandom_range(0, 3))
			0: b.wheel = $urandom_range(0, 1) ? 11'sd660 : -11'sd660;
			1: b.wheel = $urandom_range(0, 1) ? c_arm : c_fire;
			default: b.wheel = 11'($urandom_range(0, 1320) - 660);
		endcase
		b.ball_switch_open = $urandom_range(0, 1);
		b.shooter_power    = ($urandom_range(0, 9) != 0);
		b.speed_limit      = ($urandom_range(0, 2) == 0) ? pfs_pkg::SlowCode
		                     : 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: h = $urandom_range(0, 1) ? 65535 : -65535;
			1: h = int'($urandom_range(0, 131070)) - 65535;
			default: h = int'(c_heat) + int'($urandom_range(0, 6)) - 3;
		endcase
		if (h > 65535)
			h = 65535;
		b.heat_margin = 17'(h);
		b.left_rpm    = rand_rpm();
		b.right_rpm   = rand_rpm();
		if (jam_push && $urandom_range(0, 15) != 0) begin
			mag = int'(c_jamcur) + 1 + int'($urandom_range(0, 200));
			if (mag > 32768)
				mag = 32768;
			b.feeder_current = 16'(-mag);
		end else if ($urandom_range(0, 5) == 0) begin
			b.feeder_current = 16'(-int'(c_jamcur));
		end else begin
			b.feeder_current = 16'($urandom);
		end
		return b;
	endfunction

	task automatic run_random(int unsigned n);
		repeat (n) send_tick(random_tick());
	endtask

	function automatic pfs_pkg::in_beat_t steady_tick();
		pfs_pkg::in_beat_t b;
		b = '0;
		b.switch_up      = 1'b1;
		b.shooter_power  = 1'b1;
		b.heat_margin    = 17'sd1000;
		b.left_rpm       = -16'sd5000;
		b.right_rpm      = 16'sd5000;
		return b;
	endfunction

	task automatic test_directed();
		pfs_pkg::in_beat_t b;
		b = steady_tick(); b.switch_up = 1'b0; b.shooter_power = 1'b0; send_tick(b);
		b = steady_tick(); b.switch_up = 1'b0; b.toggle_key = 1'b1; send_tick(b);
		b.speed_limit = pfs_pkg::SlowCode; send_tick(b);
		b = steady_tick(); b.switch_up = 1'b0; b.shooter_power = 1'b0; send_tick(b);
		b = steady_tick(); b.switch_up = 1'b0; b.toggle_key = 1'b1; send_tick(b);
		// arm, then fire attempts short of heat and ball
		b = steady_tick(); b.ball_switch_open = 1'b1; b.wheel = -11'sd660; send_tick(b);
		b = steady_tick(); b.wheel = 11'sd660; b.heat_margin = 17'sd99; send_tick(b);
		b = steady_tick(); b.wheel = 11'sd660; b.ball_switch_open = 1'b1; send_tick(b);
		b = steady_tick(); b.wheel = 11'sd660; b.heat_margin = 17'sd100; send_tick(b);
		b = steady_tick(); b.speed_limit = pfs_pkg::SlowCode; send_tick(b);
		b = steady_tick(); b.shooter_power = 1'b0; send_tick(b);
		b = steady_tick(); b.left_rpm = 16'sd3899; send_tick(b);
		b = steady_tick(); b.left_rpm = 16'sd32767; b.right_rpm = -16'sd32768;
		b.ctrl_key = 1'b1; send_tick(b);
		// delayed mouse edge
		b = steady_tick(); b.wheel = -11'sd660; b.mouse_left = 1'b1; send_tick(b);
		b = steady_tick(); send_tick(b);
		b = steady_tick(); b.heat_margin = -17'sd65535; b.feeder_current = -16'sd32768;
		b.speed_limit = 8'd255; send_tick(b);
		b = steady_tick(); b.heat_margin = 17'sd65535; b.feeder_current = 16'sd32767;
		b.wheel = 11'sd659; send_tick(b);
		b = steady_tick(); b.ctrl_key = 1'b1; b.left_rpm = 16'sd3900;
		b.right_rpm = -16'sd3900; send_tick(b);
		b = steady_tick(); b.ball_switch_open = 1'b1; b.speed_limit = pfs_pkg::SlowCode;
		send_tick(b);
	endtask

	task automatic test_default_settings();
		jam_push = 1'b0;
		run_random(250);
	endtask

	task automatic test_jam_reverse();
		jam_push = 1'b1;
		repeat (2) begin
			apply_config(120, 600, 100, 3900, $urandom_range(1000, 20000),
				$urandom_range(0, 12), $urandom_range(0, 25));
			run_random(175);
		end
	endtask

	task automatic test_extreme_settings();
		jam_push = 1'b1;
		apply_config(-660, 660, 65535, 0, 32767, 0, 255);
		run_random(150);
		apply_config(660, -660, 0, 32767, 0, 1023, 0);
		run_random(150);
	endtask

	task automatic test_random_settings();
		repeat (3) begin
			jam_push = $urandom_range(0, 1);
			apply_config(int'($urandom_range(0, 1320)) - 660, int'($urandom_range(0, 1320)) - 660,
				$urandom_range(0, 300), $urandom_range(0, 8000), $urandom_range(0, 32767),
				$urandom_range(0, 30), $urandom_range(0, 40));
			run_random(150);
		end
	endtask

	task automatic test_back_to_back();
		jam_push = 1'b1;
		apply_config(int'($urandom_range(0, 400)) - 200, int'($urandom_range(300, 660)),
			$urandom_range(0, 200), $urandom_range(1000, 5000), $urandom_range(2000, 12000),
			$urandom_range(0, 8), $urandom_range(0, 15));
		idling = 1'b0;
		run_random(200);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_settings();
		test_jam_reverse();
		test_extreme_settings();
		test_random_settings();
		test_back_to_back();
		settle();
		repeat (8) @(posedge clk);
		$display("%0d ticks checked under %0d register settings plus defaults", n_ticks, n_cfg);
		$display("%0d shots, %0d jams seen, %0d mismatches", n_shots, n_jams, err_cnt);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
